// ===== hdl/u2a_pkg.sv =====
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types and constants for the UTF-8 to ASCII transliterator.
// ----------------------------------------------------------------------------
package u2a_pkg;

    localparam logic [7:0] CAPACITY_RESET = 8'd64;

    // Byte classes of the source stream.
    localparam logic [7:0] BYTE_END       = 8'h00;
    localparam logic [7:0] ASCII_TOP      = 8'h80;
    localparam logic [7:0] LEAD_LATIN     = 8'hC3;
    localparam logic [7:0] LEAD_THREE     = 8'hE0;
    localparam logic [7:0] LEAD_FOUR      = 8'hF0;
    localparam logic [7:0] SECOND_LOW     = 8'h80;
    localparam logic [7:0] SECOND_HIGH    = 8'hBE;

    localparam logic [1:0] SKIP_TWO_BYTE   = 2'd1;
    localparam logic [1:0] SKIP_THREE_BYTE = 2'd2;
    localparam logic [1:0] SKIP_FOUR_BYTE  = 2'd3;

    // One queue entry: the results caused by one input item.
    typedef struct packed {
        logic       two;     // second character present
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic       last;    // entry is the string terminator
    } u2a_entry_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } u2a_pair_t;

    // Replacement for a second byte after 0xC3, indexed by its low five bits.
    // A zero character means nothing is emitted.
    function automatic u2a_pair_t latin_pair(input logic [4:0] idx);
        u2a_pair_t p;
        p.first  = 8'h00;
        p.second = 8'h00;
        unique case (idx)
            5'd0, 5'd1, 5'd2, 5'd3:    p.first = "A";
            5'd4:                      begin p.first = "A"; p.second = "E"; end
            5'd7:                      p.first = "C";
            5'd8, 5'd9, 5'd10, 5'd11:  p.first = "E";
            5'd12, 5'd13, 5'd14, 5'd15: p.first = "I";
            5'd17:                     p.first = "N";
            5'd18, 5'd19, 5'd20, 5'd21: p.first = "O";
            5'd22:                     begin p.first = "O"; p.second = "E"; end
            5'd25, 5'd26, 5'd27:       p.first = "U";
            5'd28:                     begin p.first = "U"; p.second = "E"; end
            5'd31:                     begin p.first = "S"; p.second = "S"; end
            default:                   p.first = 8'h00;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/u2a_front.sv =====
// ----------------------------------------------------------------------------
// u2a_front
// Accepts source bytes, tracks the decoder state and builds one queue entry
// for each byte that produces characters, holding those characters.
// ----------------------------------------------------------------------------
module u2a_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output u2a_pkg::u2a_entry_t  q_data
);

    logic [7:0] capacity_reg;
    logic [1:0] skip_left_reg, skip_left_next;
    logic       awaiting_reg, awaiting_next;
    logic [7:0] written_reg, written_next;

    logic                accept;
    logic [7:0]          limit;
    logic                room0;
    logic                room1;
    logic                emit0;
    logic                emit1;
    logic                any_out;
    u2a_pkg::u2a_pair_t  pair;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign limit = (capacity_reg == 8'd0) ? 8'd0 : capacity_reg - 8'd1;
    assign room0 = written_reg < limit;
    assign room1 = ({1'b0, written_reg} + 9'd1) < {1'b0, limit};
    assign pair  = u2a_pkg::latin_pair(in_byte[4:0]);

    always_comb
    begin
        skip_left_next = skip_left_reg;
        awaiting_next  = awaiting_reg;
        written_next   = written_reg;
        emit0          = 1'b0;
        emit1          = 1'b0;
        q_data.two     = 1'b0;
        q_data.ch0     = in_byte;
        q_data.ch1     = pair.second;
        q_data.last    = 1'b0;
        priority if (in_byte == u2a_pkg::BYTE_END)
        begin
            // The end byte always closes the string, even inside a sequence.
            emit0          = 1'b1;
            q_data.ch0     = u2a_pkg::BYTE_END;
            q_data.last    = 1'b1;
            skip_left_next = 2'd0;
            awaiting_next  = 1'b0;
            written_next   = 8'd0;
        end
        else if (skip_left_reg != 2'd0)
        begin
            skip_left_next = skip_left_reg - 2'd1;
        end
        else if (awaiting_reg)
        begin
            awaiting_next = 1'b0;
            if (in_byte >= u2a_pkg::SECOND_LOW && in_byte <= u2a_pkg::SECOND_HIGH)
            begin
                emit0 = (pair.first != 8'd0) && room0;
                emit1 = emit0 && (pair.second != 8'd0) && room1;
            end
            q_data.ch0   = pair.first;
            q_data.two   = emit1;
            written_next = written_reg + {7'd0, emit0} + {7'd0, emit1};
        end
        else if (!room0)
        begin
            // Buffer full: bytes are consumed silently until the end byte.
        end
        else if (in_byte < u2a_pkg::ASCII_TOP)
        begin
            emit0        = 1'b1;
            written_next = written_reg + 8'd1;
        end
        else if (in_byte == u2a_pkg::LEAD_LATIN)
        begin
            awaiting_next = 1'b1;
        end
        else if (in_byte < u2a_pkg::LEAD_THREE)
        begin
            skip_left_next = u2a_pkg::SKIP_TWO_BYTE;
        end
        else if (in_byte < u2a_pkg::LEAD_FOUR)
        begin
            skip_left_next = u2a_pkg::SKIP_THREE_BYTE;
        end
        else
        begin
            skip_left_next = u2a_pkg::SKIP_FOUR_BYTE;
        end
    end

    assign any_out = emit0;
    assign q_push  = accept && any_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= u2a_pkg::CAPACITY_RESET;
            skip_left_reg <= 2'd0;
            awaiting_reg  <= 1'b0;
            written_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                skip_left_reg <= skip_left_next;
                awaiting_reg  <= awaiting_next;
                written_reg   <= written_next;
            end
        end
    end

    // A 0xC3 lead is never pending while continuation bytes are being skipped.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(awaiting_reg && (skip_left_reg != 2'd0)))
        else $error("u2a_front: skip and second-byte wait both active");

    // After an end byte the state is cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_byte == u2a_pkg::BYTE_END)) |=>
            (written_reg == 8'd0 && skip_left_reg == 2'd0 && !awaiting_reg))
        else $error("u2a_front: state not cleared after end byte");

endmodule

// ===== hdl/u2a_queue.sv =====
// ----------------------------------------------------------------------------
// u2a_queue
// Small first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module u2a_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u2a_pkg::u2a_entry_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output u2a_pkg::u2a_entry_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    u2a_pkg::u2a_entry_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == CW'(0));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("u2a_queue: push while full");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("u2a_queue: pop while empty");

endmodule

// ===== hdl/u2a_back.sv =====
// ----------------------------------------------------------------------------
// u2a_back
// Drains queue entries into the output register, one character per cycle
// while the receiver takes them, splitting two-character entries over two results.
// ----------------------------------------------------------------------------
module u2a_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  u2a_pkg::u2a_entry_t  q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 out_last
);

    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       second_reg, second_next;
    logic       load;

    // The output register may be refilled when it is empty or being taken.
    assign load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        second_next = second_reg;
        q_pop       = 1'b0;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                char_next = second_reg ? q_head.ch1 : q_head.ch0;
                last_next = q_head.last;
                q_pop     = second_reg || !q_head.two;
                second_next = !q_pop;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    // The terminator always carries a zero character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (char_reg == 8'd0))
        else $error("u2a_back: terminator with nonzero character");

    // The second half of a pair is only pending behind a two-character entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (!q_empty && q_head.two))
        else $error("u2a_back: pending second character without entry");

endmodule

// ===== hdl/utf8_to_ascii_transliterator.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator
// Turns a UTF-8 byte stream into ASCII; Latin letters after 0xC3 become uppercase.
// ----------------------------------------------------------------------------
// A result passes from the accepted byte through a queue slot and then the
// output register before it appears on the master side, held there until taken.
// Throughput: one byte per cycle while the result queue is not full; a pair such
// as AE leaves as two characters, and the queue of QUEUE_DEPTH entries absorbs the extra one.
// Reset clears the decoder state and the queue and sets capacity to 64.
module utf8_to_ascii_transliterator
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,    // capacity
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast
);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    u2a_pkg::u2a_entry_t q_in;
    u2a_pkg::u2a_entry_t q_head;

    u2a_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    u2a_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    u2a_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
